>>> src/cps_pkg.sv
`timescale 1ns / 1ps

package cps_pkg;

    // longest string position tracked before the counter saturates
    localparam longint unsigned CPS_MAX_LEN = 64'd65535;

    localparam logic [7:0] CPS_MAX_PAIRS_RST = 8'd20;

    localparam logic [7:0] CPS_CH_SPACE = 8'h20;
    localparam logic [7:0] CPS_CH_TAB   = 8'h09;
    localparam logic [7:0] CPS_CH_EQ    = 8'h3d;
    localparam logic [7:0] CPS_CH_SEMI  = 8'h3b;

    typedef struct packed {
        logic        length_overflow;
        logic        string_done;
        logic [7:0]  pairs_so_far;
        logic [15:0] value_length;
        logic [15:0] value_offset;
        logic [15:0] name_length;
        logic [15:0] name_offset;
        logic        pair_valid;
    } t_cps_rec;

endpackage

>>> src/cookie_pair_splitter_top.sv
`timescale 1ns / 1ps

// channel     | dir | tdata                     | tuser                        | tlast
// ------------+-----+---------------------------+------------------------------+------------
// s_axis      | in  | [7:0] char_in             | -                            | last_byte
// m_axis      | out | name/value offsets+lengths,| [0] pair_valid,             | string_done
//             |     | pairs_so_far (72 bits)    | [1] length_overflow          |
// cfg         | in  | i_cfg_wr_data = max_pairs | -                            | -
//
// one byte accepted every cycle while the output buffer has room; a record reaches m_axis
// from the byte that causes it via the input register, then the scanner into the output buffer
// the scanner state takes one step of compare and add per byte
// i_rst_n is synchronous; it clears the scan state, pipeline valids, max_pairs to 20
// a two-entry output buffer lets input keep flowing while a record waits on m_axis

module cookie_pair_splitter_top import cps_pkg::*; #(
    parameter longint unsigned MAX_LEN = CPS_MAX_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] char_in
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [15:0] name_offset, [31:16] name_length, [47:32] value_offset,
    // [63:48] value_length, [71:64] pairs_so_far
    output logic [71:0] o_m_axis_tdata,
    output logic [1:0]  o_m_axis_tuser,   // [0] pair_valid, [1] length_overflow
    output logic        o_m_axis_tlast
);

    logic       r_max_pairs;
    logic [7:0] r_max_pairs_q;
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;

    logic       w_rec_valid;
    t_cps_rec   w_rec;
    logic       w_space;
    logic       w_advance;
    logic       w_take;
    t_cps_rec   w_out;

    assign w_advance       = r_in_valid & (w_space | ~w_rec_valid);
    assign o_s_axis_tready = ~r_in_valid | w_advance;
    assign w_take          = i_s_axis_tvalid & o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pairs   <= 1'b1;
            r_max_pairs_q <= CPS_MAX_PAIRS_RST;
        end else if (i_cfg_wr_en) begin
            r_max_pairs   <= 1'b0;
            r_max_pairs_q <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_char <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    cps_scanner #(
        .MAX_LEN (MAX_LEN)
    ) u_scanner (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_advance),
        .i_char      (r_in_char),
        .i_last      (r_in_last),
        .i_max_pairs (r_max_pairs ? CPS_MAX_PAIRS_RST : r_max_pairs_q),
        .o_rec_valid (w_rec_valid),
        .o_rec       (w_rec)
    );

    cps_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_advance & w_rec_valid),
        .i_rec   (w_rec),
        .o_space (w_space),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_rec   (w_out)
    );

    assign o_m_axis_tdata = {w_out.pairs_so_far, w_out.value_length, w_out.value_offset,
                             w_out.name_length, w_out.name_offset};
    assign o_m_axis_tuser = {w_out.length_overflow, w_out.pair_valid};
    assign o_m_axis_tlast = w_out.string_done;

endmodule

>>> src/cps_scanner.sv
`timescale 1ns / 1ps

module cps_scanner import cps_pkg::*; #(
    parameter longint unsigned MAX_LEN = CPS_MAX_LEN
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_char,
    input  logic       i_last,
    input  logic [7:0] i_max_pairs,
    output logic       o_rec_valid,
    output t_cps_rec   o_rec
);

    localparam int POS_W = $clog2(MAX_LEN + 64'd1);
    localparam int SUM_W = POS_W + 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_LEN);

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_NAME,
        PH_VALUE
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_name_begin, n_name_begin;
    logic [POS_W-1:0] r_name_size, n_name_size;
    logic [POS_W-1:0] r_value_begin, n_value_begin;
    logic [7:0]       r_pair_total, n_pair_total;
    logic             r_ovf, n_ovf;

    t_phase           w_phase_eff;
    logic [POS_W-1:0] w_nb;
    logic [POS_W-1:0] w_pos_sat;
    logic [SUM_W-1:0] w_cur, w_cur_inc;
    logic [SUM_W-1:0] w_no, w_nl, w_vo, w_vl;
    logic             w_emit;
    logic             w_ovf;
    logic [7:0]       w_total;

    function automatic logic [SUM_W-1:0] span(input logic [SUM_W-1:0] from,
                                              input logic [SUM_W-1:0] to);
        return (to > from) ? (to - from) : '0;
    endfunction

    always_comb begin
        n_phase       = r_phase;
        n_pos         = r_pos;
        n_name_begin  = r_name_begin;
        n_name_size   = r_name_size;
        n_value_begin = r_value_begin;
        n_pair_total  = r_pair_total;
        n_ovf         = r_ovf;

        w_phase_eff = r_phase;
        w_nb        = r_name_begin;
        w_emit      = 1'b0;
        w_no        = '0;
        w_nl        = '0;
        w_vo        = '0;
        w_vl        = '0;

        w_cur     = {1'b0, r_pos};
        w_cur_inc = w_cur + 1'b1;
        w_pos_sat = (r_pos == POS_LAST) ? r_pos : (r_pos + 1'b1);
        w_ovf     = r_ovf | (r_pos == POS_LAST);

        if (r_pair_total < i_max_pairs) begin
            if (r_phase == PH_SKIP && i_char != CPS_CH_SPACE && i_char != CPS_CH_TAB) begin
                w_nb         = r_pos;
                w_phase_eff  = PH_NAME;
                n_name_begin = r_pos;
                n_phase      = PH_NAME;
            end
            if (w_phase_eff == PH_NAME) begin
                if (i_char == CPS_CH_EQ) begin
                    n_name_size   = POS_W'(span({1'b0, w_nb}, w_cur));
                    n_value_begin = w_pos_sat;
                    n_phase       = PH_VALUE;
                    if (i_last) begin
                        // value opens on the final byte, so it is empty
                        w_emit = 1'b1;
                        w_no   = {1'b0, w_nb};
                        w_nl   = span({1'b0, w_nb}, w_cur);
                        w_vo   = w_cur_inc;
                    end
                end else if (i_char == CPS_CH_SEMI) begin
                    w_emit  = 1'b1;
                    w_no    = {1'b0, w_nb};
                    w_nl    = span({1'b0, w_nb}, w_cur);
                    w_vo    = w_cur;
                    n_phase = PH_SKIP;
                end
            end else if (w_phase_eff == PH_VALUE) begin
                if (i_char == CPS_CH_SEMI) begin
                    w_emit  = 1'b1;
                    w_no    = {1'b0, r_name_begin};
                    w_nl    = {1'b0, r_name_size};
                    w_vo    = {1'b0, r_value_begin};
                    w_vl    = span({1'b0, r_value_begin}, w_cur);
                    n_phase = PH_SKIP;
                end else if (i_last) begin
                    w_emit = 1'b1;
                    w_no   = {1'b0, r_name_begin};
                    w_nl   = {1'b0, r_name_size};
                    w_vo   = {1'b0, r_value_begin};
                    w_vl   = span({1'b0, r_value_begin}, w_cur_inc);
                end
            end
            if (w_emit) begin
                n_pair_total = r_pair_total + 1'b1;
            end
        end

        w_total = n_pair_total;
        n_pos   = w_pos_sat;
        n_ovf   = w_ovf;

        if (i_last) begin
            n_phase       = PH_SKIP;
            n_pos         = '0;
            n_name_begin  = '0;
            n_name_size   = '0;
            n_value_begin = '0;
            n_pair_total  = '0;
            n_ovf         = 1'b0;
        end
    end

    always_comb begin
        o_rec_valid           = w_emit | i_last;
        o_rec.pair_valid      = w_emit;
        o_rec.name_offset     = 16'(w_no);
        o_rec.name_length     = 16'(w_nl);
        o_rec.value_offset    = 16'(w_vo);
        o_rec.value_length    = 16'(w_vl);
        o_rec.pairs_so_far    = w_total;
        o_rec.string_done     = i_last;
        o_rec.length_overflow = w_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SKIP;
            r_pos         <= '0;
            r_name_begin  <= '0;
            r_name_size   <= '0;
            r_value_begin <= '0;
            r_pair_total  <= '0;
            r_ovf         <= 1'b0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_pos         <= n_pos;
            r_name_begin  <= n_name_begin;
            r_name_size   <= n_name_size;
            r_value_begin <= n_value_begin;
            r_pair_total  <= n_pair_total;
            r_ovf         <= n_ovf;
        end
    end

endmodule

>>> src/cps_out_buf.sv
`timescale 1ns / 1ps

module cps_out_buf import cps_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_cps_rec i_rec,
    output logic     o_space,
    output logic     o_valid,
    input  logic     i_ready,
    output t_cps_rec o_rec
);

    logic     r_main_valid;
    logic     r_skid_valid;
    t_cps_rec r_main;
    t_cps_rec r_skid;
    logic     w_pop;

    assign w_pop   = r_main_valid & i_ready;
    assign o_space = ~r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_rec   = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_pop && r_skid_valid) begin
                r_main_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end else if (w_pop) begin
                r_main_valid <= i_push;
            end else if (i_push) begin
                if (!r_main_valid) begin
                    r_main_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end
        end
    end

    // payload path, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_pop && r_skid_valid) begin
            r_main <= r_skid;
        end else if (w_pop || (i_push && !r_main_valid)) begin
            r_main <= i_rec;
        end else if (i_push) begin
            r_skid <= i_rec;
        end
    end

endmodule

>>> src/cps_checker.sv
`timescale 1ns / 1ps

module cps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [71:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    // nothing leaves the block in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // a stalled transaction keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled output transaction changed");

    // a record without a pair carries zero offsets and lengths and marks the string done
    a_empty_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata[63:0] == 64'd0
            && o_m_axis_tlast)
        else $error("record without pair carries offsets or is not done");

    // a reported pair counts itself
    a_pair_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata[71:64] != 8'd0)
        else $error("pair reported with zero pair count");

endmodule

bind cookie_pair_splitter_top cps_checker u_cps_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

>>> tb/cps_record_checker.sv
`timescale 1ns / 1ps

module cps_record_checker import cps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_in
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // [15:0] name_offset, [31:16] name_length, [47:32] value_offset,
    // [63:48] value_length, [71:64] pairs_so_far
    input  logic [71:0] i_m_tdata,
    input  logic [1:0]  i_m_tuser,   // [0] pair_valid, [1] length_overflow
    input  logic        i_m_tlast,
    output int          o_fail_count,
    output int          o_recs_waiting
);

    typedef enum logic [1:0] {SCAN_SKIP, SCAN_NAME, SCAN_VALUE} t_scan;

    localparam int unsigned POS_CAP = 32'(CPS_MAX_LEN);

    logic [7:0]  max_pairs_q;
    t_scan       scan_q;
    int unsigned pos_q;
    int unsigned name_at;
    int unsigned name_span;
    int unsigned value_at;
    logic [7:0]  pairs_q;
    logic        overflow_q;
    t_cps_rec    pair_recs[$];
    int          fails = 0;
    t_cps_rec    got;

    assign o_fail_count = fails;
    assign got = {i_m_tuser[1], i_m_tlast, i_m_tdata[71:64], i_m_tdata[63:48],
                  i_m_tdata[47:32], i_m_tdata[31:16], i_m_tdata[15:0], i_m_tuser[0]};

    function automatic int unsigned cap_pos(input int unsigned p);
        return (p > POS_CAP) ? POS_CAP : p;
    endfunction

    function automatic int unsigned len_between(input int unsigned lo, input int unsigned hi);
        return (hi > lo) ? hi - lo : 0;
    endfunction

    function automatic void clear_scan();
        scan_q     = SCAN_SKIP;
        pos_q      = 0;
        name_at    = 0;
        name_span  = 0;
        value_at   = 0;
        pairs_q    = 8'd0;
        overflow_q = 1'b0;
    endfunction

    // one byte of the header value; queues the record it causes, if any
    function automatic void split_step(input logic [7:0] ch, input logic fin);
        int unsigned here;
        logic        hit;
        t_cps_rec    rec;
        here = pos_q;
        hit  = 1'b0;
        rec  = '0;
        if (here >= POS_CAP) overflow_q = 1'b1;
        if (pairs_q < max_pairs_q) begin
            if (scan_q == SCAN_SKIP && ch != CPS_CH_SPACE && ch != CPS_CH_TAB) begin
                name_at = here;
                scan_q  = SCAN_NAME;
            end
            if (scan_q == SCAN_NAME) begin
                if (ch == CPS_CH_EQ) begin
                    name_span = len_between(name_at, here);
                    value_at  = cap_pos(here + 1);
                    scan_q    = SCAN_VALUE;
                    if (fin) begin
                        hit              = 1'b1;
                        rec.name_offset  = 16'(name_at);
                        rec.name_length  = 16'(name_span);
                        // not saturated here, wraps past the position cap
                        rec.value_offset = 16'(here + 1);
                    end
                end else if (ch == CPS_CH_SEMI) begin
                    hit              = 1'b1;
                    rec.name_offset  = 16'(name_at);
                    rec.name_length  = 16'(len_between(name_at, here));
                    rec.value_offset = 16'(here);
                    scan_q           = SCAN_SKIP;
                end
            end else if (scan_q == SCAN_VALUE) begin
                if (ch == CPS_CH_SEMI || fin) begin
                    hit              = 1'b1;
                    rec.name_offset  = 16'(name_at);
                    rec.name_length  = 16'(name_span);
                    rec.value_offset = 16'(value_at);
                    rec.value_length = 16'(len_between(value_at,
                                           (ch == CPS_CH_SEMI) ? here : here + 1));
                    if (ch == CPS_CH_SEMI) scan_q = SCAN_SKIP;
                end
            end
            if (hit) pairs_q++;
        end
        pos_q = cap_pos(here + 1);
        if (hit || fin) begin
            rec.pair_valid      = hit;
            rec.pairs_so_far    = pairs_q;
            rec.string_done     = fin;
            rec.length_overflow = overflow_q;
            pair_recs = {pair_recs, rec};
        end
        if (fin) clear_scan();
    endfunction

    function automatic void check_record(input t_cps_rec seen);
        t_cps_rec want;
        if (pair_recs.size() == 0) begin
            if (fails < 10)
                $display("record with nothing pending: valid %0b pairs %0d done %0b",
                         seen.pair_valid, seen.pairs_so_far, seen.string_done);
            fails++;
            return;
        end
        want = pair_recs.pop_front();
        if (seen.pair_valid !== want.pair_valid || seen.name_offset !== want.name_offset ||
            seen.name_length !== want.name_length ||
            seen.value_offset !== want.value_offset ||
            seen.value_length !== want.value_length ||
            seen.pairs_so_far !== want.pairs_so_far ||
            seen.string_done !== want.string_done ||
            seen.length_overflow !== want.length_overflow) begin
            if (fails < 10) begin
                $write("record mismatch (exp/got): valid %0b/%0b name %0d+%0d/%0d+%0d ",
                       want.pair_valid, seen.pair_valid,
                       want.name_offset, want.name_length,
                       seen.name_offset, seen.name_length);
                $display("value %0d+%0d/%0d+%0d pairs %0d/%0d done %0b/%0b ovf %0b/%0b",
                         want.value_offset, want.value_length,
                         seen.value_offset, seen.value_length,
                         want.pairs_so_far, seen.pairs_so_far,
                         want.string_done, seen.string_done,
                         want.length_overflow, seen.length_overflow);
            end
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            max_pairs_q = CPS_MAX_PAIRS_RST;
            clear_scan();
            pair_recs.delete();
        end else begin
            if (i_cfg_wr_en) max_pairs_q = i_cfg_wr_data;
            if (i_s_tvalid && i_s_tready) split_step(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready) check_record(got);
        end
        o_recs_waiting <= pair_recs.size();
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import cps_pkg::*;

    localparam int RANDOM_BYTES = 650;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    int          fail_count;
    int          recs_waiting;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          bytes_sent = 0;

    cookie_pair_splitter_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    cps_record_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tlast      (s_tlast),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_m_tuser      (m_tuser),
        .i_m_tlast      (m_tlast),
        .o_fail_count   (fail_count),
        .o_recs_waiting (recs_waiting)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        m_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end

    task automatic send_byte(input logic [7:0] ch, input logic fin);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= fin;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_string(input logic [7:0] text[$]);
        foreach (text[i]) send_byte(text[i], i == text.size() - 1);
    endtask

    task automatic send_text(input string s);
        logic [7:0] text[$];
        for (int i = 0; i < s.len(); i++) text = {text, s[i]};
        send_string(text);
    endtask

    // every expected record out, then a settling wait for the pipeline
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (recs_waiting != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_pairs(input logic [7:0] limit);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [7:0] name_char();
        logic [7:0] ch;
        do ch = 8'($urandom_range(255, 0)); while (ch == CPS_CH_EQ || ch == CPS_CH_SEMI);
        return ch;
    endfunction

    function automatic logic [7:0] value_char();
        logic [7:0] ch;
        do ch = 8'($urandom_range(255, 0)); while (ch == CPS_CH_SEMI);
        return ch;
    endfunction

    function automatic logic [7:0] noisy_char();
        case ($urandom_range(5, 0))
            0: return CPS_CH_SPACE;
            1: return CPS_CH_TAB;
            2: return CPS_CH_EQ;
            3: return CPS_CH_SEMI;
            default: return 8'($urandom_range(255, 0));
        endcase
    endfunction

    task automatic send_pairs();
        logic [7:0] text[$];
        int         n;
        n = $urandom_range(6, 1);
        for (int k = 0; k < n; k++) begin
            repeat ($urandom_range(2, 0))
                text = {text, ($urandom_range(1, 0) ? CPS_CH_SPACE : CPS_CH_TAB)};
            repeat ($urandom_range(4, 0)) text = {text, name_char()};
            if ($urandom_range(3, 0) != 0) begin
                text = {text, CPS_CH_EQ};
                repeat ($urandom_range(5, 0)) text = {text, value_char()};
            end
            if (k < n - 1 || $urandom_range(2, 0) == 0) text = {text, CPS_CH_SEMI};
        end
        if (text.size() == 0) text = {text, CPS_CH_SEMI};
        send_string(text);
    endtask

    task automatic send_random_string();
        logic [7:0] text[$];
        if ($urandom_range(4, 0) != 0) begin
            send_pairs();
        end else begin
            repeat ($urandom_range(10, 1)) text = {text, noisy_char()};
            send_string(text);
        end
    endtask

    initial begin
        logic [7:0] text[$];
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 9;
        rx_idle_pct = 54;

        // reset limit of 20 pairs
        send_text(" \tab=c;k;;=v;x");
        send_text("n=");
        send_text("a=b");
        text = {8'hff};
        send_string(text);
        text = {8'h00, CPS_CH_SEMI};
        send_string(text);

        write_max_pairs(8'd0);
        repeat (3) send_pairs();
        write_max_pairs(8'd255);
        while (bytes_sent < RANDOM_BYTES / 3) send_random_string();

        tx_idle_pct = 54;
        rx_idle_pct = 9;
        while (bytes_sent < 2 * RANDOM_BYTES / 3) begin
            write_max_pairs(8'($urandom_range(4, 1)));
            repeat (8) send_random_string();
        end

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_max_pairs(8'($urandom_range(30, 1)));
        while (bytes_sent < RANDOM_BYTES) send_random_string();

        wait_idle();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
